### design/chlg_pkg.sv
// Shared widths, codes, constants and the load band lookup for the core-count governor.
package chlg_pkg;

  // Field widths
  localparam int unsigned LOAD_W     = 9;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned LOCK_W     = 32;
  localparam int unsigned HLEN_W     = 6;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Fixed system constants
  localparam int unsigned NUM_CORES        = 4;
  localparam int unsigned DEF_MAX_HISTORY  = 32;
  localparam int unsigned MIN_BOOST_GAP_US = 150000;

  // Register reset values
  localparam logic              RST_ENABLED     = 1'b0;
  localparam logic [CNT_W-1:0]  RST_MIN_ONLINE  = 3'd1;
  localparam logic [CNT_W-1:0]  RST_MAX_ONLINE  = 3'd4;
  localparam logic [CNT_W-1:0]  RST_BOOST_COUNT = 3'd1;
  localparam logic [PCT_W-1:0]  RST_FAST_LANE   = 7'd95;
  localparam logic [LOCK_W-1:0] RST_BOOST_LOCK  = 32'd4000000;
  localparam logic [HLEN_W-1:0] RST_HISTORY_LEN = 6'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED     = 3'd0,
    CFG_MIN_ONLINE  = 3'd1,
    CFG_MAX_ONLINE  = 3'd2,
    CFG_BOOST_COUNT = 3'd3,
    CFG_FAST_LANE   = 3'd4,
    CFG_BOOST_LOCK  = 3'd5,
    CFG_HISTORY_LEN = 3'd6
  } cfg_index_e;

  // Request codes on the result channel
  typedef enum logic [REQ_W-1:0] {
    REQ_NONE = 2'd0,
    REQ_UP   = 2'd1,
    REQ_DOWN = 2'd2
  } request_e;

  // Load bands: band i+1 covers (BAND_DOWN[i], BAND_UP[i]]
  localparam int unsigned BAND_COUNT = 4;
  localparam logic [LOAD_W-1:0] BAND_UP [BAND_COUNT] = '{9'd65, 9'd120, 9'd190, 9'd410};
  localparam logic [LOAD_W-1:0] BAND_DOWN [BAND_COUNT] = '{9'd0, 9'd50, 9'd100, 9'd170};

  // First matching band gives the core count; zero when no band matches.
  function automatic logic [CNT_W-1:0] band_target(input logic [LOAD_W-1:0] avg);
    logic [CNT_W-1:0] tgt;
    logic             hit;
    tgt = '0;
    hit = 1'b0;
    for (int i = 0; i < BAND_COUNT; i++) begin
      if (!hit && (avg <= BAND_UP[i]) && (avg > BAND_DOWN[i])) begin
        tgt = CNT_W'(i + 1);
        hit = 1'b1;
      end
    end
    return tgt;
  endfunction

endpackage

### design/cpu_hotplug_load_governor.sv
// Core-count governor: load history memory, averaging divider and online-core decision.
// Each accepted transaction yields exactly one result. A load sample with history length
// L > 1 writes the sample into the history memory, reads entries 0..L-1 back one per cycle
// through the registered read port, divides the sum by L in a restoring divider that
// retires one quotient bit a cycle and then decides. With L = 1 the memory is skipped and
// the sample goes straight to the divider. A user input event passes a check state and
// an event decision state. A stalled result register holds the block in its decision state
// until it is free. The block takes one transaction at a time; the result register lets
// the next transaction be accepted while a result waits.
// The history reads as zero after reset and after every history_len write through one
// valid bit per entry, so no clearing pass is needed. Configuration writes are always
// accepted and hold off the input channel in that cycle; they must only be issued while
// the block is idle.
module cpu_hotplug_load_governor
  import chlg_pkg::*;
#(
  parameter int unsigned MAX_HISTORY = DEF_MAX_HISTORY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [TIME_W-1:0]     now_us_i,
  input  logic [LOAD_W-1:0]     load_sum_i,
  input  logic [PCT_W-1:0]      peak_load_i,
  input  logic [CNT_W-1:0]      cores_online_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [REQ_W-1:0]      request_o,
  output logic [CNT_W-1:0]      target_cores_o,
  output logic [LOAD_W-1:0]     average_load_o
);

  localparam int unsigned IDXW = $clog2(MAX_HISTORY);
  localparam int unsigned LENW = $clog2(MAX_HISTORY + 1);
  localparam int unsigned SUMW = LOAD_W + LENW;
  localparam int unsigned DCW  = $clog2(SUMW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DECIDE,
    ST_EVT_CHK,
    ST_EVT
  } state_e;

  // Bring-up is allowed when enabled, the target is higher and headroom is left.
  function automatic logic up_allowed(input logic en, input logic [CNT_W-1:0] tgt,
                                      input logic [CNT_W-1:0] online,
                                      input logic [CNT_W-1:0] max_on);
    return en && (tgt > online) && (online < max_on);
  endfunction

  state_e               state_q;

  // Configuration registers
  logic                 enabled_q;
  logic [CNT_W-1:0]     min_online_q;
  logic [CNT_W-1:0]     max_online_q;
  logic [CNT_W-1:0]     boost_count_q;
  logic [PCT_W-1:0]     fast_lane_q;
  logic [LOCK_W-1:0]    boost_lock_q;
  logic [HLEN_W-1:0]    history_len_q;

  // Governor state
  logic [IDXW-1:0]        hist_idx_q;
  logic [MAX_HISTORY-1:0] hist_vld_q;
  logic [TIME_W-1:0]      last_input_q;
  logic [TIME_W-1:0]      last_boost_q;
  logic [LOAD_W-1:0]      last_avg_q;

  // Captured transaction
  logic [TIME_W-1:0]    now_q;
  logic [PCT_W-1:0]     peak_q;
  logic [CNT_W-1:0]     online_q;

  // Summing and division
  logic [LENW-1:0]      rd_cnt_q;
  logic                 rd_pend_q;
  logic                 rd_hit_q;
  logic [LOAD_W-1:0]    rd_data_q;
  logic [SUMW-1:0]      quo_q;
  logic [LENW-1:0]      rem_q;
  logic [DCW-1:0]       div_cnt_q;
  logic                 lock_q;
  logic                 gap_q;

  // Result register
  logic                 out_valid_q;
  logic [REQ_W-1:0]     request_q;
  logic [CNT_W-1:0]     target_q;
  logic [LOAD_W-1:0]    average_q;

  // History memory
  logic [LOAD_W-1:0]    hist_mem [MAX_HISTORY];

  logic                 accept_in;
  logic                 accept_cfg;
  logic                 out_free;
  logic                 res_load;
  logic [LENW-1:0]      len_eff;
  logic                 len_gt1;
  logic [IDXW-1:0]      slot;
  logic [LENW-1:0]      slot_nxt;
  logic [IDXW-1:0]      idx_wrap;
  logic                 hist_wr;
  logic [IDXW-1:0]      rd_addr;
  logic [SUMW-1:0]      sum_add;
  logic [LENW:0]        div_shift;
  logic                 div_ge;
  logic [LENW-1:0]      rem_nxt;
  logic [TIME_W-1:0]    since_input;
  logic [TIME_W-1:0]    since_boost;
  logic [LOAD_W-1:0]    avg;
  logic [CNT_W-1:0]     band_t;
  logic [CNT_W-1:0]     clamp_t;
  logic [CNT_W-1:0]     cand_t;
  logic                 cand_up;
  logic                 cand_dn;
  logic                 down_ok;
  request_e             smp_req;
  logic [CNT_W-1:0]     smp_tgt;
  logic                 boost_hit;
  logic                 evt_up;

  // A configuration write in the same cycle takes precedence over the input channel.
  assign accept_in   = in_valid_i && in_ready_o;
  assign accept_cfg  = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign res_load    = out_free && ((state_q == ST_DECIDE) || (state_q == ST_EVT));

  // Effective history length: zero acts as one, oversize acts as the memory depth.
  always_comb begin
    if (history_len_q == '0) begin
      len_eff = LENW'(1);
    end else if (32'(history_len_q) > MAX_HISTORY) begin
      len_eff = LENW'(MAX_HISTORY);
    end else begin
      len_eff = LENW'(history_len_q);
    end
  end
  assign len_gt1 = (len_eff > LENW'(1));

  // Write slot and ring index advance.
  assign slot     = (LENW'(hist_idx_q) >= len_eff) ? '0 : hist_idx_q;
  assign slot_nxt = LENW'(slot) + LENW'(1);
  assign idx_wrap = (slot_nxt >= len_eff) ? '0 : slot_nxt[IDXW-1:0];
  assign hist_wr  = accept_in && !action_i && len_gt1;
  assign rd_addr  = rd_cnt_q[IDXW-1:0];

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (hist_wr) begin
      hist_mem[slot] <= load_sum_i;
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  // Accumulation and one restoring division step.
  assign sum_add   = quo_q + (rd_hit_q ? SUMW'(rd_data_q) : '0);
  assign div_shift = {rem_q, quo_q[SUMW-1]};
  assign div_ge    = (div_shift >= {1'b0, len_eff});
  assign rem_nxt   = div_ge ? LENW'(div_shift - {1'b0, len_eff}) : div_shift[LENW-1:0];

  // Elapsed times since the last input event and the last boost.
  assign since_input = now_q - last_input_q;
  assign since_boost = now_q - last_boost_q;

  // Sample decision: fast lane, pinned counts, then the clamped load band.
  assign avg    = quo_q[LOAD_W-1:0];
  assign band_t = band_target(avg);
  always_comb begin
    if (band_t > max_online_q) begin
      clamp_t = max_online_q;
    end else if (band_t < min_online_q) begin
      clamp_t = min_online_q;
    end else begin
      clamp_t = band_t;
    end

    cand_t  = clamp_t;
    cand_up = 1'b0;
    cand_dn = 1'b0;
    if (peak_q >= fast_lane_q) begin
      cand_t  = max_online_q;
      cand_up = 1'b1;
    end else if (min_online_q == CNT_W'(NUM_CORES)) begin
      cand_t  = min_online_q;
      cand_up = (online_q != min_online_q);
    end else if (max_online_q == CNT_W'(1)) begin
      cand_t  = max_online_q;
      cand_dn = (online_q != max_online_q);
    end else begin
      cand_up = (clamp_t > online_q);
      cand_dn = (clamp_t < online_q);
    end

    down_ok = enabled_q && (cand_t < online_q) && (online_q > min_online_q) &&
              !((online_q <= boost_count_q) && lock_q);

    smp_req = REQ_NONE;
    smp_tgt = '0;
    if (cand_up && up_allowed(enabled_q, cand_t, online_q, max_online_q)) begin
      smp_req = REQ_UP;
      smp_tgt = cand_t;
    end else if (cand_dn && down_ok) begin
      smp_req = REQ_DOWN;
      smp_tgt = cand_t;
    end
  end

  // Input event decision: boost when the gap has passed and boosting would add cores.
  assign boost_hit = gap_q && (online_q < boost_count_q) && (boost_count_q > min_online_q);
  assign evt_up    = boost_hit &&
                     up_allowed(enabled_q, boost_count_q, online_q, max_online_q);

  // Sequencer, configuration, state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      enabled_q     <= RST_ENABLED;
      min_online_q  <= RST_MIN_ONLINE;
      max_online_q  <= RST_MAX_ONLINE;
      boost_count_q <= RST_BOOST_COUNT;
      fast_lane_q   <= RST_FAST_LANE;
      boost_lock_q  <= RST_BOOST_LOCK;
      history_len_q <= RST_HISTORY_LEN;
      hist_idx_q    <= '0;
      hist_vld_q    <= '0;
      last_input_q  <= '0;
      last_boost_q  <= '0;
      last_avg_q    <= '0;
      now_q         <= '0;
      peak_q        <= '0;
      online_q      <= '0;
      rd_cnt_q      <= '0;
      rd_pend_q     <= 1'b0;
      rd_hit_q      <= 1'b0;
      quo_q         <= '0;
      rem_q         <= '0;
      div_cnt_q     <= '0;
      lock_q        <= 1'b0;
      gap_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      request_q     <= '0;
      target_q      <= '0;
      average_q     <= '0;
    end else begin
      rd_hit_q <= hist_vld_q[rd_addr];
      lock_q   <= (since_input < TIME_W'(boost_lock_q));
      gap_q    <= (since_boost >= TIME_W'(MIN_BOOST_GAP_US));

      // Result valid is set when a result is loaded and cleared when it is taken.
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Configuration writes
      if (accept_cfg) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_ENABLED:     enabled_q     <= cfg_data_i[0];
          CFG_MIN_ONLINE:  min_online_q  <= cfg_data_i[CNT_W-1:0];
          CFG_MAX_ONLINE:  max_online_q  <= cfg_data_i[CNT_W-1:0];
          CFG_BOOST_COUNT: boost_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_FAST_LANE:   fast_lane_q   <= cfg_data_i[PCT_W-1:0];
          CFG_BOOST_LOCK:  boost_lock_q  <= cfg_data_i[LOCK_W-1:0];
          CFG_HISTORY_LEN: begin
            history_len_q <= cfg_data_i[HLEN_W-1:0];
            hist_vld_q    <= '0;
            hist_idx_q    <= '0;
          end
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept_in) begin
            now_q     <= now_us_i;
            peak_q    <= peak_load_i;
            online_q  <= cores_online_i;
            rd_cnt_q  <= '0;
            rd_pend_q <= 1'b0;
            rem_q     <= '0;
            div_cnt_q <= '0;
            if (action_i) begin
              state_q <= ST_EVT_CHK;
            end else if (len_gt1) begin
              hist_vld_q[slot] <= 1'b1;
              hist_idx_q       <= idx_wrap;
              quo_q            <= '0;
              state_q          <= ST_SUM;
            end else begin
              quo_q   <= SUMW'(load_sum_i);
              state_q <= ST_DIV;
            end
          end
        end

        // Read entries 0..L-1 and accumulate them one per cycle.
        ST_SUM: begin
          if (rd_cnt_q < len_eff) begin
            rd_cnt_q  <= rd_cnt_q + LENW'(1);
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q) begin
            quo_q <= sum_add;
          end
          if (rd_pend_q && (rd_cnt_q == len_eff)) begin
            state_q <= ST_DIV;
          end
        end

        // One quotient bit per cycle, most significant first.
        ST_DIV: begin
          rem_q     <= rem_nxt;
          quo_q     <= {quo_q[SUMW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(SUMW - 1)) begin
            state_q <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (out_free) begin
            request_q   <= smp_req;
            target_q    <= smp_tgt;
            average_q   <= avg;
            last_avg_q  <= avg;
            state_q     <= ST_IDLE;
          end
        end

        // Let the boost gap compare settle from the captured time.
        ST_EVT_CHK: begin
          state_q <= ST_EVT;
        end

        ST_EVT: begin
          if (out_free) begin
            last_input_q <= now_q;
            if (boost_hit) begin
              last_boost_q <= now_q;
            end
            request_q   <= evt_up ? REQ_UP : REQ_NONE;
            target_q    <= evt_up ? boost_count_q : '0;
            average_q   <= last_avg_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign request_o      = request_q;
  assign target_cores_o = target_q;
  assign average_load_o = average_q;

  // An accepted transaction always starts work.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> (state_q != ST_IDLE))
    else $error("accepted transaction did not leave idle");

  // The ring index stays inside the effective history length between samples.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (LENW'(hist_idx_q) < len_eff))
    else $error("history index outside the history length");

  // The read counter never runs past the history length while summing.
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (rd_cnt_q <= len_eff))
    else $error("history read counter overran");

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < len_eff))
    else $error("divider remainder not below divisor");

  // A result without a request carries no target.
  a_none_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (request_o == REQ_NONE)) |-> (target_cores_o == '0))
    else $error("target given without a request");

endmodule
